@@ hdl/countdown_timer_bank_macros.svh @@
// Assertion macros shared by the countdown timer bank.
`ifndef COUNTDOWN_TIMER_BANK_MACROS_SVH
`define COUNTDOWN_TIMER_BANK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("countdown timer bank assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("countdown timer bank assertion failed");

`endif

@@ hdl/ctb_pkg.sv @@
// Shared constants, operation codes and control structs of the countdown timer bank.
package ctb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 16;
    localparam int PCT_W      = 7;
    localparam int QUO_W      = 7;
    localparam int STEP_W     = 3;
    localparam int REM_W      = 23;
    localparam int PCT_MAX    = 100;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_QUERY = 2'd3
    } ctb_op_t;

    typedef struct packed {
        logic apply;
        logic load;
        logic step;
        logic out_write;
    } ctb_cmd_t;

    typedef struct packed {
        logic div_last;
    } ctb_status_t;

endpackage

@@ hdl/ctb_datapath.sv @@
// Timer store, percent divider and result register of the countdown timer bank.
module ctb_datapath
    import ctb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  ctb_cmd_t           cmd,
    output ctb_status_t        status,
    input  ctb_op_t            in_op,
    input  logic [ID_W-1:0]    in_id,
    input  logic [CNT_W-1:0]   in_frames,
    output logic               out_is_active,
    output logic               out_is_done,
    output logic [CNT_W-1:0]   out_remaining,
    output logic [PCT_W-1:0]   out_percent
);

    logic             active_reg [NUM_TIMERS];
    logic             active_next[NUM_TIMERS];
    logic [CNT_W-1:0] count_reg  [NUM_TIMERS];
    logic [CNT_W-1:0] count_next [NUM_TIMERS];
    logic [CNT_W-1:0] init_reg   [NUM_TIMERS];
    logic [CNT_W-1:0] init_next  [NUM_TIMERS];

    logic              in_ok;
    logic [IDX_W-1:0]  in_idx;
    logic              ok_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              rd_act;
    logic [CNT_W-1:0]  rd_cnt;
    logic [CNT_W-1:0]  rd_init;

    logic              act_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;

    logic [REM_W-1:0]  den_sh;
    logic              rem_ge;
    logic [REM_W-1:0]  rem_diff;
    logic [PCT_W-1:0]  pct_sat;

    logic              res_act_reg;
    logic              res_done_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic [PCT_W-1:0]  res_pct_reg;

    assign in_ok  = {1'b0, in_id} < (ID_W + 1)'(NUM_TIMERS);
    assign in_idx = in_id[IDX_W-1:0];

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            active_next[i] = active_reg[i];
            count_next[i]  = count_reg[i];
            init_next[i]   = init_reg[i];
        end
        if (cmd.apply) begin
            case (in_op)
                OP_TICK: begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (active_reg[i]) begin
                            count_next[i]  = (count_reg[i] != '0) ? count_reg[i] - 1'b1
                                                                   : count_reg[i];
                            active_next[i] = count_reg[i] > CNT_W'(1);
                        end
                    end
                end
                OP_START: begin
                    if (in_ok) begin
                        active_next[in_idx] = in_frames != '0;
                        count_next[in_idx]  = in_frames;
                        init_next[in_idx]   = in_frames;
                    end
                end
                OP_STOP: begin
                    if (in_ok) begin
                        active_next[in_idx] = 1'b0;
                        count_next[in_idx]  = '0;
                    end
                end
                OP_QUERY: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                active_reg[i] <= 1'b0;
                count_reg[i]  <= '0;
                init_reg[i]   <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                active_reg[i] <= active_next[i];
                count_reg[i]  <= count_next[i];
                init_reg[i]   <= init_next[i];
            end
        end
    end

    assign rd_act  = ok_reg & active_reg[idx_reg];
    assign rd_cnt  = ok_reg ? count_reg[idx_reg] : '0;
    assign rd_init = ok_reg ? init_reg[idx_reg] : '0;

    // Restoring division of 100 * count by the initial count, one quotient bit per step.
    assign den_sh   = REM_W'({den_reg, {(QUO_W - 1){1'b0}}});
    assign rem_ge   = rem_reg >= den_sh;
    assign rem_diff = rem_reg - den_sh;
    assign pct_sat  = (quo_reg > QUO_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(quo_reg);

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            ok_reg  <= in_ok;
            idx_reg <= in_idx;
        end
        if (cmd.load) begin
            act_reg  <= rd_act;
            cnt_reg  <= rd_cnt;
            den_reg  <= rd_init;
            rem_reg  <= REM_W'(rd_cnt) * REM_W'(PCT_MAX);
            quo_reg  <= '0;
            step_reg <= STEP_W'(QUO_W - 1);
        end else if (cmd.step) begin
            rem_reg  <= (rem_ge ? rem_diff : rem_reg) << 1;
            quo_reg  <= {quo_reg[QUO_W-2:0], rem_ge};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.out_write) begin
            res_act_reg  <= act_reg;
            res_done_reg <= ~act_reg;
            res_cnt_reg  <= cnt_reg;
            res_pct_reg  <= (den_reg == '0) ? '0 : pct_sat;
        end
    end

    assign status.div_last = step_reg == '0;

    assign out_is_active = res_act_reg;
    assign out_is_done   = res_done_reg;
    assign out_remaining = res_cnt_reg;
    assign out_percent   = res_pct_reg;

endmodule

@@ hdl/ctb_controller.sv @@
// Sequencing state machine and result valid flag of the countdown timer bank.
module ctb_controller
    import ctb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output ctb_cmd_t    cmd,
    input  ctb_status_t status
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } ctb_state_t;

    ctb_state_t state_reg;
    ctb_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg & ~m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.apply  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_write  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ hdl/countdown_timer_bank.sv @@
// Top level of the countdown timer bank: controller, datapath and stream ports.
// A result is written to the result register in the done state, after the load and divide states of its item.
// A new item is taken only when the seven-step percent divider is through with the last one.
// The result register lets the next item enter while a result waits to be taken.
// Reset (aresetn low, synchronous) clears all timers and the result valid flag.
`include "countdown_timer_bank_macros.svh"

module countdown_timer_bank
    import ctb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operation[1:0], timer_id[9:2], frames[25:10], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // is_active[0], is_done[1], remaining[17:2],
                                   // percent_left[24:18], zeros
);

    ctb_cmd_t         cmd;
    ctb_status_t      status;
    logic             is_active;
    logic             is_done;
    logic [CNT_W-1:0] remaining;
    logic [PCT_W-1:0] percent_left;

    ctb_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ctb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_op         (ctb_op_t'(s_tdata[1:0])),
        .in_id         (s_tdata[9:2]),
        .in_frames     (s_tdata[25:10]),
        .out_is_active (is_active),
        .out_is_done   (is_done),
        .out_remaining (remaining),
        .out_percent   (percent_left)
    );

    assign m_tdata = {7'b0, percent_left, remaining, is_done, is_active};

    `CTB_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CTB_ASSERT_NOW(a_done_is_not_active, aclk, aresetn, m_tvalid, m_tdata[1] != m_tdata[0])
    `CTB_ASSERT_NOW(a_percent_in_range, aclk, aresetn, m_tvalid, m_tdata[24:18] <= 7'd100)
    `CTB_ASSERT_NOW(a_active_has_count, aclk, aresetn, m_tvalid && m_tdata[0],
                    m_tdata[17:2] != 16'd0)

endmodule
